// ===== rtl/bcs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bcs_pkg
// Shared types and constants of the Plackett copula pair sampler pipeline.
// ----------------------------------------------------------------------------
package bcs_pkg;

    localparam int UniW   = 16;                 // Q0.16 sample width
    localparam int ThetaW = 24;                 // Q8.16 theta width
    localparam int SqW    = 56;                 // radicand width
    localparam int RootW  = SqW / 2;            // root width
    localparam int RemW   = RootW + 3;          // root remainder width
    localparam int DenW   = 32;                 // divisor width
    localparam int QW     = 16;                 // quotient bits
    localparam int CW     = 51;                 // c term width

    localparam logic [16:0]       ONE_Q16   = 17'h10000;
    localparam logic [ThetaW-1:0] THETA_ONE = 24'h010000;
    localparam logic [ThetaW-1:0] THETA_RST = 24'h020000;

    // input transaction payload
    typedef struct packed {
        logic [UniW-1:0] first_uniform;
        logic [UniW-1:0] second_uniform;
    } t_in;

    // output transaction payload
    typedef struct packed {
        logic [UniW-1:0] sample_u;
        logic [UniW-1:0] sample_v;
    } t_out;

    // per-item data carried alongside the arithmetic
    typedef struct packed {
        logic [UniW-1:0]    u;
        logic [UniW-1:0]    t;
        logic               sel_u;   // min copula
        logic               sel_t;   // independence
        logic signed [17:0] s;       // 1 - 2t
        logic [CW-1:0]      c;
        logic [DenW-1:0]    den;
        logic               zero;    // numerator not positive
        logic               sat;     // quotient above range
    } t_side;

endpackage
`default_nettype wire

// ===== rtl/bcs_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bcs_front
// Four register stages forming a, b, c, the divisor and the radicand.
// ----------------------------------------------------------------------------
module bcs_front (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_en,
    input  wire                      i_valid,
    input  wire bcs_pkg::t_in        i_data,
    input  wire [bcs_pkg::ThetaW-1:0] i_theta,
    output logic                     o_valid,
    output bcs_pkg::t_side           o_side,
    output logic [bcs_pkg::SqW-1:0]  o_sq
);
    import bcs_pkg::*;

    // stage 1 signals
    logic [16:0]       w_omt, w_omu;
    logic [32:0]       w_a32, w_uu32;
    logic [47:0]       w_thsq;
    logic [ThetaW-1:0] w_tm1;
    t_side             n1_side;

    logic              r1_valid;
    t_side             r1_side;
    logic [15:0]       r1_a16, r1_uu16;
    logic [31:0]       r1_thsq16;
    logic [ThetaW-1:0] r1_tm1;

    // stage 1: t(1-t), u(1-u), the square of theta and |theta-1|
    always_comb begin
        w_omt  = ONE_Q16 - {1'b0, i_data.second_uniform};
        w_omu  = ONE_Q16 - {1'b0, i_data.first_uniform};
        w_a32  = 33'(i_data.second_uniform) * 33'(w_omt);
        w_uu32 = 33'(i_data.first_uniform) * 33'(w_omu);
        w_thsq = 48'(i_theta) * 48'(i_theta);
        w_tm1  = (i_theta >= THETA_ONE) ? i_theta - THETA_ONE : THETA_ONE - i_theta;
        n1_side       = '0;
        n1_side.u     = i_data.first_uniform;
        n1_side.t     = i_data.second_uniform;
        n1_side.sel_u = (i_theta == '0);
        n1_side.sel_t = (i_theta == THETA_ONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_side   <= n1_side;
            r1_a16    <= w_a32[31:16];
            r1_uu16   <= w_uu32[31:16];
            r1_thsq16 <= w_thsq[47:16];
            r1_tm1    <= w_tm1;
        end
    end

    // stage 2 signals
    logic [47:0] w_tm1sq;
    logic [31:0] w_p32;
    logic [16:0] w_omu2, w_mtwo;
    logic [48:0] w_x;
    logic [40:0] w_thc;
    t_side       n2_side;

    logic        r2_valid;
    t_side       r2_side;
    logic [47:0] r2_tm1sq;
    logic [15:0] r2_p16, r2_a16;
    logic [48:0] r2_x;
    logic [40:0] r2_thc;

    // stage 2: (theta-1)^2, a*u(1-u), x and theta(1-2a)
    always_comb begin
        w_tm1sq = 48'(r1_tm1) * 48'(r1_tm1);
        w_p32   = r1_a16 * r1_uu16;
        w_omu2  = ONE_Q16 - {1'b0, r1_side.u};
        w_x     = 49'(r1_side.u) * 49'(r1_thsq16) + {16'b0, w_omu2, 16'b0};
        w_mtwo  = ONE_Q16 - {r1_a16, 1'b0};
        w_thc   = 41'(i_theta) * 41'(w_mtwo);
        n2_side   = r1_side;
        n2_side.s = $signed(18'(ONE_Q16) - 18'({r1_side.t, 1'b0}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_side  <= n2_side;
            r2_tm1sq <= w_tm1sq;
            r2_p16   <= w_p32[31:16];
            r2_a16   <= r1_a16;
            r2_x     <= w_x;
            r2_thc   <= w_thc;
        end
    end

    // stage 3 signals
    logic [63:0] w_bprod, w_pprod;
    logic [64:0] w_axprod;
    logic [47:0] w_b;
    logic [48:0] w_inner;
    t_side       n3_side;

    logic        r3_valid;
    t_side       r3_side;
    logic [47:0] r3_b;
    logic [48:0] r3_inner;

    // stage 3: b, c and the term under the root
    always_comb begin
        w_bprod  = 64'(r2_a16) * 64'(r2_tm1sq);
        w_axprod = 65'(r2_a16) * 65'(r2_x);
        w_pprod  = 64'(r2_p16) * 64'(r2_tm1sq);
        w_b      = {8'b0, i_theta, 16'b0} + w_bprod[63:16];
        w_inner  = {9'b0, i_theta, 16'b0} + {1'b0, w_pprod[61:16], 2'b00};
        n3_side   = r2_side;
        n3_side.c = {1'b0, w_axprod[64:16], 1'b0} + CW'(r2_thc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_side  <= n3_side;
            r3_b     <= w_b;
            r3_inner <= w_inner;
        end
    end

    // stage 4: radicand and divisor
    t_side n4_side;

    always_comb begin
        n4_side     = r3_side;
        n4_side.den = r3_b[46:15];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_side <= n4_side;
            o_sq   <= SqW'(r3_inner[47:16]) * SqW'(i_theta);
        end
    end

endmodule
`default_nettype wire

// ===== rtl/bcs_sqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bcs_sqrt
// Pipelined floor square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module bcs_sqrt (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_en,
    input  wire                       i_valid,
    input  wire bcs_pkg::t_side       i_side,
    input  wire [bcs_pkg::SqW-1:0]    i_sq,
    output logic                      o_valid,
    output bcs_pkg::t_side            o_side,
    output logic [bcs_pkg::RootW-1:0] o_root
);
    import bcs_pkg::*;

    logic             r_valid [0:RootW-1];
    t_side            r_side  [0:RootW-1];
    logic [RemW-1:0]  r_rem   [0:RootW-1];
    logic [RootW-1:0] r_root  [0:RootW-1];
    logic [SqW-1:0]   r_x     [0:RootW-1];

    for (genvar k = 0; k < RootW; k++) begin : g_step
        logic             w_valid_in;
        t_side            w_side_in;
        logic [RemW-1:0]  w_rem_in, w_cur, w_trial;
        logic [RootW-1:0] w_root_in;
        logic [SqW-1:0]   w_x_in;

        // previous stage or pipeline input
        if (k == 0) begin : g_first
            assign w_valid_in = i_valid;
            assign w_side_in  = i_side;
            assign w_rem_in   = '0;
            assign w_root_in  = '0;
            assign w_x_in     = i_sq;
        end else begin : g_next
            assign w_valid_in = r_valid[k-1];
            assign w_side_in  = r_side[k-1];
            assign w_rem_in   = r_rem[k-1];
            assign w_root_in  = r_root[k-1];
            assign w_x_in     = r_x[k-1];
        end

        // bring down two radicand bits and try the next root bit
        assign w_cur   = {w_rem_in[RemW-3:0], w_x_in[SqW-1 -: 2]};
        assign w_trial = {1'b0, w_root_in, 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= w_valid_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k] <= w_side_in;
                r_x[k]    <= {w_x_in[SqW-3:0], 2'b00};
                if (w_cur >= w_trial) begin
                    r_rem[k]  <= w_cur - w_trial;
                    r_root[k] <= {w_root_in[RootW-2:0], 1'b1};
                end else begin
                    r_rem[k]  <= w_cur;
                    r_root[k] <= {w_root_in[RootW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_valid[RootW-1];
    assign o_side  = r_side[RootW-1];
    assign o_root  = r_root[RootW-1];

endmodule
`default_nettype wire

// ===== rtl/bcs_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bcs_div
// Numerator c - (1-2t)d, range checks and a pipelined restoring divider.
// ----------------------------------------------------------------------------
module bcs_div (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_en,
    input  wire                       i_valid,
    input  wire bcs_pkg::t_side       i_side,
    input  wire [bcs_pkg::RootW-1:0]  i_root,
    output logic                      o_valid,
    output bcs_pkg::t_side            o_side,
    output logic [bcs_pkg::QW-1:0]    o_quot
);
    import bcs_pkg::*;

    // product stage
    logic               r_m1_valid;
    t_side              r_m1_side;
    logic signed [46:0] r_m1_sd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_valid <= 1'b0;
        end else if (i_en) begin
            r_m1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m1_side <= i_side;
            r_m1_sd   <= 47'(i_side.s) * 47'($signed({1'b0, i_root}));
        end
    end

    // numerator stage: sign and overflow checks
    logic signed [52:0] w_num;
    logic [35:0]        w_numhi;
    t_side              n_m2_side;

    logic               r_m2_valid;
    t_side              r_m2_side;
    logic [DenW-1:0]    r_m2_rem;
    logic [QW-1:0]      r_m2_low;

    always_comb begin
        w_num   = $signed({2'b00, r_m1_side.c}) - 53'(r_m1_sd);
        w_numhi = w_num[51:16];
        n_m2_side      = r_m1_side;
        n_m2_side.zero = w_num[52] || (w_num == '0);
        n_m2_side.sat  = (w_numhi >= {4'b0, r_m1_side.den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_valid <= 1'b0;
        end else if (i_en) begin
            r_m2_valid <= r_m1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m2_side <= n_m2_side;
            r_m2_rem  <= w_numhi[DenW-1:0];
            r_m2_low  <= w_num[QW-1:0];
        end
    end

    // divider stages, one quotient bit each
    logic            r_valid [0:QW-1];
    t_side           r_side  [0:QW-1];
    logic [DenW-1:0] r_rem   [0:QW-1];
    logic [QW-1:0]   r_low   [0:QW-1];
    logic [QW-1:0]   r_quot  [0:QW-1];

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic            w_valid_in;
        t_side           w_side_in;
        logic [DenW-1:0] w_rem_in;
        logic [QW-1:0]   w_low_in, w_quot_in;
        logic [DenW:0]   w_cur, w_diff;

        if (k == 0) begin : g_first
            assign w_valid_in = r_m2_valid;
            assign w_side_in  = r_m2_side;
            assign w_rem_in   = r_m2_rem;
            assign w_low_in   = r_m2_low;
            assign w_quot_in  = '0;
        end else begin : g_next
            assign w_valid_in = r_valid[k-1];
            assign w_side_in  = r_side[k-1];
            assign w_rem_in   = r_rem[k-1];
            assign w_low_in   = r_low[k-1];
            assign w_quot_in  = r_quot[k-1];
        end

        // shift in the next numerator bit and compare with the divisor
        assign w_cur  = {w_rem_in, w_low_in[QW-1]};
        assign w_diff = w_cur - {1'b0, w_side_in.den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= w_valid_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k] <= w_side_in;
                r_low[k]  <= {w_low_in[QW-2:0], 1'b0};
                if (w_cur >= {1'b0, w_side_in.den}) begin
                    r_rem[k]  <= w_diff[DenW-1:0];
                    r_quot[k] <= {w_quot_in[QW-2:0], 1'b1};
                end else begin
                    r_rem[k]  <= w_cur[DenW-1:0];
                    r_quot[k] <= {w_quot_in[QW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_valid[QW-1];
    assign o_side  = r_side[QW-1];
    assign o_quot  = r_quot[QW-1];

endmodule
`default_nettype wire

// ===== rtl/bivariate_copula_sampler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bivariate_copula_sampler
// Plackett copula pair sampler: (u, t) in, dependent pair (u, v) out.
// ----------------------------------------------------------------------------
// Input channel i_in_valid / o_in_ready carries u and t in Q0.16; output
// channel o_out_valid / i_out_ready carries (u, v). The configuration channel
// i_cfg_valid / o_cfg_ready writes theta (Q8.16) and is always ready; the user
// writes it only while no transaction is in flight; the block does not enforce it.
// Throughput: one transaction per cycle while the receiver does not stall. From
// input acceptance to output valid an item passes 4 arithmetic stages, 28
// square-root stages (one root bit each), 2 numerator stages, 16 divider
// stages (one quotient bit each) and the output register.
// Theta 0 returns v = u, theta 1.0 returns v = t; otherwise v is the
// conditional inverse, 0 for a non-positive numerator, 65535 on overflow.
// Reset (synchronous, active low) empties the pipeline and sets theta to 2.0.
// When the receiver stalls, the whole pipeline holds; input is still taken
// while the output register is empty or being emptied in that cycle.
// ----------------------------------------------------------------------------
module bivariate_copula_sampler (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_in_valid,
    output logic                       o_in_ready,
    input  wire bcs_pkg::t_in          i_in_data,
    output logic                       o_out_valid,
    input  wire                        i_out_ready,
    output bcs_pkg::t_out              o_out_data,
    input  wire                        i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire [bcs_pkg::ThetaW-1:0]  i_cfg_data
);
    import bcs_pkg::*;

    logic [ThetaW-1:0] r_theta;
    logic              w_en;
    logic              w_f_valid, w_s_valid, w_d_valid;
    t_side             w_f_side, w_s_side, w_d_side;
    logic [SqW-1:0]    w_sq;
    logic [RootW-1:0]  w_root;
    logic [QW-1:0]     w_quot;
    t_out              n_out;

    // theta register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_theta <= THETA_RST;
        end else if (i_cfg_valid) begin
            r_theta <= i_cfg_data;
        end
    end

    // pipeline advance
    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    bcs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .i_theta (r_theta),
        .o_valid (w_f_valid),
        .o_side  (w_f_side),
        .o_sq    (w_sq)
    );

    bcs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_valid),
        .i_side  (w_f_side),
        .i_sq    (w_sq),
        .o_valid (w_s_valid),
        .o_side  (w_s_side),
        .o_root  (w_root)
    );

    bcs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_s_valid),
        .i_side  (w_s_side),
        .i_root  (w_root),
        .o_valid (w_d_valid),
        .o_side  (w_d_side),
        .o_quot  (w_quot)
    );

    // result selection
    always_comb begin
        n_out.sample_u = w_d_side.u;
        if (w_d_side.sel_u) begin
            n_out.sample_v = w_d_side.u;
        end else if (w_d_side.sel_t) begin
            n_out.sample_v = w_d_side.t;
        end else if (w_d_side.zero) begin
            n_out.sample_v = '0;
        end else if (w_d_side.sat) begin
            n_out.sample_v = '1;
        end else begin
            n_out.sample_v = w_quot;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_en) begin
            o_out_valid <= w_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_out_data <= n_out;
        end
    end

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Plackett copula pair sampler.
// A scoreboard class works out each expected (u, v) pair in 64-bit integer
// arithmetic as pairs are accepted, and compares the results in order. The
// run goes through several theta settings, the extremes among them. Each
// setting gets a directed set of corner samples, then random samples, under
// changing sender and receiver idle patterns. One long receiver hold-off
// fills the pipeline so that its input stalls.
// ----------------------------------------------------------------------------
class copula_scoreboard;
    logic [bcs_pkg::ThetaW-1:0] theta;
    bcs_pkg::t_out              pair_q[$];
    int                         mismatches;
    int                         checked;

    function new();
        theta      = bcs_pkg::THETA_RST;
        mismatches = 0;
        checked    = 0;
    endfunction

    // integer floor square root
    static function longint unsigned isqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // conditional inversion of the copula at level t
    function logic [15:0] dependent_v(longint unsigned u, longint unsigned t);
        longint unsigned one, th, tm1, tm1sq, a16, b, thsq16, x, c, uu16, p16, inner, d, den;
        longint          s, num;
        longint unsigned q;
        one = 65536;
        th  = theta;
        if (th == 0) return u[15:0];
        if (th == one) return t[15:0];
        tm1    = (th >= one) ? th - one : one - th;
        tm1sq  = tm1 * tm1;
        a16    = (t * (one - t)) >> 16;
        b      = (th << 16) + ((a16 * tm1sq) >> 16);
        thsq16 = (th * th) >> 16;
        x      = u * thsq16 + ((one - u) << 16);
        c      = (((a16 * x) >> 16) << 1) + th * (one - (a16 << 1));
        uu16   = (u * (one - u)) >> 16;
        p16    = (a16 * uu16) >> 16;
        inner  = (th << 16) + (((p16 * tm1sq) >> 16) << 2);
        d      = isqrt((inner >> 16) * th);
        s      = longint'(one) - 2 * longint'(t);
        num    = longint'(c) - s * longint'(d);
        den    = (b << 1) >> 16;
        if (num <= 0) return 16'd0;
        if (den == 0) return 16'hFFFF;
        q = longint'(num) / den;
        if (q > 65535) q = 65535;
        return q[15:0];
    endfunction

    // note an accepted input pair
    function void note_input(bcs_pkg::t_in item);
        bcs_pkg::t_out exp_pair;
        exp_pair.sample_u = item.first_uniform;
        exp_pair.sample_v = dependent_v(item.first_uniform, item.second_uniform);
        pair_q.push_back(exp_pair);
    endfunction

    // compare an accepted result with the oldest expected pair
    function void check_result(bcs_pkg::t_out got);
        bcs_pkg::t_out exp_pair;
        if (pair_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result u=%0d v=%0d", got.sample_u, got.sample_v);
            return;
        end
        exp_pair = pair_q.pop_front();
        checked++;
        if (got.sample_u !== exp_pair.sample_u || got.sample_v !== exp_pair.sample_v) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch theta=%0d: expected u=%0d v=%0d, got u=%0d v=%0d",
                         theta, exp_pair.sample_u, exp_pair.sample_v,
                         got.sample_u, got.sample_v);
        end
    endfunction
endclass

module tb;
    import bcs_pkg::*;

    localparam int DRAIN_CYCLES = 60;
    localparam int STALL_LIMIT  = 20000;
    localparam int HOLD_CYCLES  = 400;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in                   i_in_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out                  o_out_data;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [ThetaW-1:0]     i_cfg_data;

    copula_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_request;
    int  quiet_cycles;
    int  sent_count;

    bivariate_copula_sampler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver ready, with random stalls and one long hold-off
    always @(negedge i_clk) begin
        int hold_left;
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor, scoreboard hookup and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) sb.note_input(i_in_data);
            if (o_out_valid && i_out_ready) sb.check_result(o_out_data);
            if (i_cfg_valid && o_cfg_ready) sb.theta = i_cfg_data;
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // send one input transaction
    task automatic send_pair(input logic [15:0] u, input logic [15:0] t);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid               = 1'b1;
        i_in_data.first_uniform  = u;
        i_in_data.second_uniform = t;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        sent_count++;
    endtask

    // wait until every expected result is in, then let the pipe settle
    task automatic drain();
        while (sb.pair_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // write theta while idle
    task automatic write_theta(input logic [ThetaW-1:0] value);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // one theta setting: corner pairs, then random pairs
    task automatic run_phase(input int phase, input logic [ThetaW-1:0] th, input int count);
        logic [15:0] corner[5];
        logic [15:0] u, t;
        corner = '{16'd0, 16'd1, 16'd32768, 16'd65534, 16'd65535};
        write_theta(th);
        case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
            default: begin send_idle_pct = 32; recv_stall_pct = 32; end
        endcase
        for (int i = 0; i < 5; i++)
            for (int j = 0; j < 5; j += 2)
                send_pair(corner[i], corner[j]);
        if (phase == 2) begin
            send_idle_pct = 0;
            hold_request  = 1'b1;
        end
        for (int k = 0; k < count; k++) begin
            // mostly full-range samples, some near the edges
            if ($urandom_range(9) == 0) begin
                u = corner[$urandom_range(4)];
                t = 16'($urandom);
            end else begin
                u = 16'($urandom);
                t = 16'($urandom);
            end
            send_pair(u, t);
            if (k == 40) send_idle_pct = (phase % 4 == 1) ? 70 : (phase % 4 == 3) ? 32 : 0;
        end
        drain();
    endtask

    initial begin
        logic [ThetaW-1:0] thetas[10];
        sb             = new();
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        i_out_ready    = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b0;
        quiet_cycles   = 0;
        sent_count     = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        thetas = '{THETA_RST, 24'd0, THETA_ONE, 24'hFFFFFF, 24'd1,
                   24'h00FFFF, 24'h010001, 24'h008000, 24'h123456, 24'h000000};
        thetas[9] = ThetaW'($urandom_range(24'hFFFFFF));
        for (int p = 0; p < 10; p++)
            run_phase(p, thetas[p], 170);

        $display("covered %0d sample pairs over 10 theta settings, %0d results checked",
                 sent_count, sb.checked);
        $display("settings include theta 0, 1.0, the smallest and the largest value");
        if (sb.mismatches == 0 && sb.pair_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pair_q.size());
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/bcs_pkg.sv
rtl/bcs_front.sv
rtl/bcs_sqrt.sv
rtl/bcs_div.sv
rtl/bivariate_copula_sampler.sv
tb/tb.sv
